>>> sv/kspa_pkg.sv
// kspa_pkg: shared types, widths and Q27 coefficient tables for the Kelvin
// ber/bei polynomial pipeline. No dependencies.
package kspa_pkg;

    localparam int ACC_FRAC  = 27;
    localparam int X_W       = 21;
    localparam int VAL_W     = 24;
    localparam int OPD_W     = 28;          // t, s, u: at most 1.0 in Q27
    localparam int MAG_W     = 36;          // |p| stays below 2^35 in range
    localparam int COEF_W    = 37;          // signed accumulator width
    localparam int N_COEF    = 8;
    localparam int N_HORNER  = 7;
    localparam int N_MAC     = 9;           // Horner steps plus two scaling steps
    localparam int RND_HALF  = 1 << (ACC_FRAC - 1);
    localparam longint unsigned DEC_SCALE = 64'd100000000;

    typedef enum logic [1:0] {
        OP_BER  = 2'd0,
        OP_BEI  = 2'd1,
        OP_BERD = 2'd2,
        OP_BEID = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic                       neg;
        logic                       rerr;
        logic [OPD_W-1:0]           t;
        logic [OPD_W-1:0]           s;
        logic [OPD_W-1:0]           u;
        logic signed [COEF_W-1:0]   p;
    } kspa_item_t;

    typedef logic [3:0][N_COEF-1:0][COEF_W-1:0] coef_tab_t;

    // published 8-decimal coefficients, scaled by 1e8; index 7 is zero for
    // the seven-term polynomials
    localparam longint C_DEC [4][N_COEF] = '{
        '{64'sd100000000, -64'sd6400000000, 64'sd11377777774, -64'sd3236345652,
          64'sd264191397, -64'sd8349609, 64'sd122552, -64'sd901},
        '{64'sd1600000000, -64'sd11377777774, 64'sd7281777742, -64'sd1056765779,
          64'sd52185615, -64'sd1103667, 64'sd11346, 64'sd0},
        '{-64'sd400000000, 64'sd1422222222, -64'sd606814810, 64'sd66047849,
          -64'sd2609253, 64'sd45957, -64'sd394, 64'sd0},
        '{64'sd50000000, -64'sd1066666666, 64'sd1137777772, -64'sd231167514,
          64'sd14677204, -64'sd379386, 64'sd4609, 64'sd0}
    };

    // decimal to Q27, round to nearest, ties away from zero
    function automatic coef_tab_t build_tab();
        coef_tab_t         tab;
        longint unsigned   m;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < N_COEF; j++) begin
                m = (C_DEC[i][j] < 0) ? 64'(-C_DEC[i][j]) : 64'(C_DEC[i][j]);
                m = ((m << ACC_FRAC) + DEC_SCALE / 2) / DEC_SCALE;
                tab[i][j] = (C_DEC[i][j] < 0) ? COEF_W'(-m) : COEF_W'(m);
            end
        end
        return tab;
    endfunction

    localparam coef_tab_t COEF_Q = build_tab();

endpackage

>>> sv/kspa_if.sv
// kspa_if: valid/ready channel interfaces for argument and result words.
// Depends on kspa_pkg.
interface kspa_arg_if;
    logic                              valid;
    logic                              ready;
    kspa_pkg::op_t                     op;
    logic signed [kspa_pkg::X_W-1:0]   x;

    modport source (output valid, output op, output x, input ready);
    modport sink   (input valid, input op, input x, output ready);
endinterface

interface kspa_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [kspa_pkg::VAL_W-1:0]   value;
    logic                                range_error;

    modport source (output valid, output value, output range_error, input ready);
    modport sink   (input valid, input value, input range_error, output ready);
endinterface

>>> sv/kspa_arg.sv
// kspa_arg: front end, three register stages: |x| and range check to t = |x|/8,
// then s = t*t, then u = s*s plus the leading Horner coefficient. Uses kspa_pkg.
module kspa_arg #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  kspa_pkg::op_t                      op,
    input  logic signed [kspa_pkg::X_W-1:0]    x,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output kspa_pkg::kspa_item_t               dn_item
);

    localparam longint unsigned X_MAX = 64'd8 << FRAC_BITS;
    localparam int T_W = kspa_pkg::X_W + 12;

    logic                       va_reg, vb_reg, vc_reg;
    logic                       ra, rb, rc;
    kspa_pkg::kspa_item_t       a_next, a_reg, b_next, b_reg, c_next, c_reg;
    logic [kspa_pkg::X_W-1:0]   xu;
    logic [kspa_pkg::X_W-1:0]   mag;
    logic [T_W-1:0]             t_wide;
    logic [2*kspa_pkg::OPD_W-1:0] sq_t, sq_s;
    logic [2*kspa_pkg::OPD_W:0]   rnd_t, rnd_s;

    assign rc       = !vc_reg || dn_ready;
    assign rb       = !vb_reg || rc;
    assign ra       = !va_reg || rb;
    assign up_ready = ra;
    assign dn_valid = vc_reg;
    assign dn_item  = c_reg;

    assign xu  = x;
    assign mag = xu[kspa_pkg::X_W-1] ? kspa_pkg::X_W'(~xu + 1'b1) : xu;

    // t = |x|/8 in Q27
    generate
        if (FRAC_BITS <= kspa_pkg::ACC_FRAC - 3) begin : g_tl
            localparam int TSH = kspa_pkg::ACC_FRAC - 3 - FRAC_BITS;
            assign t_wide = {12'd0, mag} << TSH;
        end else begin : g_tr
            localparam int RSH = FRAC_BITS - (kspa_pkg::ACC_FRAC - 3);
            assign t_wide = ({12'd0, mag} + (T_W'(1) << (RSH - 1))) >> RSH;
        end
    endgenerate

    always_comb
    begin
        a_next      = '0;
        a_next.op   = op;
        a_next.neg  = xu[kspa_pkg::X_W-1];
        a_next.rerr = {43'd0, mag} > X_MAX;
        a_next.t    = t_wide[kspa_pkg::OPD_W-1:0];
    end

    assign sq_t  = a_reg.t * a_reg.t;
    assign rnd_t = {1'b0, sq_t} + (2*kspa_pkg::OPD_W+1)'(kspa_pkg::RND_HALF);
    always_comb
    begin
        b_next   = a_reg;
        b_next.s = rnd_t[kspa_pkg::ACC_FRAC +: kspa_pkg::OPD_W];
    end

    assign sq_s  = b_reg.s * b_reg.s;
    assign rnd_s = {1'b0, sq_s} + (2*kspa_pkg::OPD_W+1)'(kspa_pkg::RND_HALF);
    always_comb
    begin
        c_next   = b_reg;
        c_next.u = rnd_s[kspa_pkg::ACC_FRAC +: kspa_pkg::OPD_W];
        c_next.p = signed'(kspa_pkg::COEF_Q[b_reg.op][kspa_pkg::N_COEF-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ra) va_reg <= up_valid;
            if (rb) vb_reg <= va_reg;
            if (rc) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ra) a_reg <= a_next;
        if (rb) b_reg <= b_next;
        if (rc) c_reg <= c_next;
    end

endmodule

>>> sv/kspa_mac.sv
// kspa_mac: one multiply/round/add register stage. Steps 0..6 are Horner steps
// in u; step 7 scales by s (bei, ber') or t (bei') and passes ber, step 8 by t (ber'). Uses kspa_pkg.
module kspa_mac #(
    parameter int STEP = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  kspa_pkg::kspa_item_t    up_item,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output kspa_pkg::kspa_item_t    dn_item
);

    localparam logic [kspa_pkg::OPD_W-1:0] ONE_Q = kspa_pkg::OPD_W'(1) << kspa_pkg::ACC_FRAC;
    localparam int PROD_W = kspa_pkg::MAG_W + kspa_pkg::OPD_W;

    logic                               v_reg;
    logic                               rdy;
    kspa_pkg::kspa_item_t               item_next, item_reg;
    logic [kspa_pkg::COEF_W-1:0]        p_abs;
    logic [kspa_pkg::MAG_W-1:0]         mag;
    logic [kspa_pkg::OPD_W-1:0]         mul_opd;
    logic signed [kspa_pkg::COEF_W-1:0] addend;
    logic [PROD_W-1:0]                  prod;
    logic [PROD_W:0]                    rnd;
    logic [kspa_pkg::COEF_W-1:0]        r;
    logic signed [kspa_pkg::COEF_W-1:0] r_signed;

    assign rdy      = !v_reg || dn_ready;
    assign up_ready = rdy;
    assign dn_valid = v_reg;
    assign dn_item  = item_reg;

    generate
        if (STEP < kspa_pkg::N_HORNER) begin : g_horner
            assign mul_opd = up_item.u;
            assign addend  = signed'(kspa_pkg::COEF_Q[up_item.op][kspa_pkg::N_HORNER-1-STEP]);
        end else if (STEP == kspa_pkg::N_HORNER) begin : g_scale1
            always_comb
            begin
                case (up_item.op)
                    kspa_pkg::OP_BER:  mul_opd = ONE_Q;
                    kspa_pkg::OP_BEI:  mul_opd = up_item.s;
                    kspa_pkg::OP_BERD: mul_opd = up_item.s;
                    kspa_pkg::OP_BEID: mul_opd = up_item.t;
                    default:           mul_opd = ONE_Q;
                endcase
            end
            assign addend = '0;
        end else begin : g_scale2
            assign mul_opd = (up_item.op == kspa_pkg::OP_BERD) ? up_item.t : ONE_Q;
            assign addend  = '0;
        end
    endgenerate

    // sign-magnitude product, magnitude rounded half away from zero
    assign p_abs    = up_item.p[kspa_pkg::COEF_W-1] ? kspa_pkg::COEF_W'(-up_item.p)
                                                    : kspa_pkg::COEF_W'(up_item.p);
    assign mag      = p_abs[kspa_pkg::MAG_W-1:0];
    assign prod     = mag * mul_opd;
    assign rnd      = {1'b0, prod} + (PROD_W+1)'(kspa_pkg::RND_HALF);
    assign r        = rnd[kspa_pkg::ACC_FRAC +: kspa_pkg::COEF_W];
    assign r_signed = up_item.p[kspa_pkg::COEF_W-1] ? signed'(-r) : signed'(r);

    always_comb
    begin
        item_next   = up_item;
        item_next.p = r_signed + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy)
            item_reg <= item_next;
    end

endmodule

>>> sv/kspa_round.sv
// kspa_round: output register stage: Q27 (or Q24 for derivatives) to FRAC_BITS,
// sign fix, saturation to 24 bits, zero on range error. Uses kspa_pkg.
module kspa_round #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 up_valid,
    output logic                                 up_ready,
    input  kspa_pkg::kspa_item_t                 up_item,
    output logic                                 dn_valid,
    input  logic                                 dn_ready,
    output logic signed [kspa_pkg::VAL_W-1:0]    value,
    output logic                                 range_error
);

    localparam int W    = kspa_pkg::MAG_W + 7;
    localparam int F27  = kspa_pkg::ACC_FRAC;
    localparam int F24  = kspa_pkg::ACC_FRAC - 3;
    localparam int L27  = (FRAC_BITS >= F27) ? FRAC_BITS - F27 : 0;
    localparam int R27  = (FRAC_BITS <  F27) ? F27 - FRAC_BITS : 0;
    localparam int L24  = (FRAC_BITS >= F24) ? FRAC_BITS - F24 : 0;
    localparam int R24  = (FRAC_BITS <  F24) ? F24 - FRAC_BITS : 0;
    localparam int R27M = (R27 > 0) ? R27 - 1 : 0;
    localparam int R24M = (R24 > 0) ? R24 - 1 : 0;
    localparam logic [W-1:0] POS_LIM = W'(1) << (kspa_pkg::VAL_W - 1);

    logic                               v_reg;
    logic                               rdy;
    logic                               rerr_reg;
    logic signed [kspa_pkg::VAL_W-1:0]  value_reg, value_next;
    logic [kspa_pkg::COEF_W-1:0]        p_abs;
    logic [W-1:0]                       m, w27, w24, sel, lim, msat;
    logic                               deriv, neg_out;

    assign rdy         = !v_reg || dn_ready;
    assign up_ready    = rdy;
    assign dn_valid    = v_reg;
    assign value       = value_reg;
    assign range_error = rerr_reg;

    assign p_abs = up_item.p[kspa_pkg::COEF_W-1] ? kspa_pkg::COEF_W'(-up_item.p)
                                                 : kspa_pkg::COEF_W'(up_item.p);
    assign m     = {7'd0, p_abs[kspa_pkg::MAG_W-1:0]};

    always_comb
    begin
        if (FRAC_BITS >= F27)
            w27 = m << L27;
        else
            w27 = (m + (W'(1) << R27M)) >> R27;
        if (FRAC_BITS >= F24)
            w24 = m << L24;
        else
            w24 = (m + (W'(1) << R24M)) >> R24;
    end

    // derivatives carry the Q24 scale of x*P and the sign of x
    assign deriv   = up_item.op inside {kspa_pkg::OP_BERD, kspa_pkg::OP_BEID};
    assign sel     = deriv ? w24 : w27;
    assign neg_out = up_item.p[kspa_pkg::COEF_W-1] ^ (deriv & up_item.neg);
    assign lim     = neg_out ? POS_LIM : POS_LIM - 1'b1;
    assign msat    = (sel > lim) ? lim : sel;

    always_comb
    begin
        if (up_item.rerr)
            value_next = '0;
        else if (neg_out)
            value_next = signed'(-msat[kspa_pkg::VAL_W-1:0]);
        else
            value_next = signed'(msat[kspa_pkg::VAL_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy)
        begin
            value_reg <= value_next;
            rerr_reg  <= up_item.rerr;
        end
    end

endmodule

>>> sv/kelvin_small_arg_poly_top.sv
// Kelvin ber/bei/ber'/bei' small-argument evaluator, 13 register stages.
// Throughput: one word per cycle; stages fill bubbles on their own, and a stalled
// result word stalls the input only once all 13 stages hold words.
// Reset (rst_n, async, active low) clears all stage valid bits; no other state.
// Depends on kspa_pkg, kspa_if, kspa_arg, kspa_mac, kspa_round.
module kelvin_small_arg_poly_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    kspa_arg_if.sink    arg,
    kspa_res_if.source  res
);

    logic                   mac_valid [kspa_pkg::N_MAC+1];
    logic                   mac_ready [kspa_pkg::N_MAC+1];
    kspa_pkg::kspa_item_t   mac_item  [kspa_pkg::N_MAC+1];

    kspa_arg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (arg.valid),
        .up_ready (arg.ready),
        .op       (arg.op),
        .x        (arg.x),
        .dn_valid (mac_valid[0]),
        .dn_ready (mac_ready[0]),
        .dn_item  (mac_item[0])
    );

    generate
        for (genvar k = 0; k < kspa_pkg::N_MAC; k++) begin : g_mac
            kspa_mac #(
                .STEP (k)
            ) u_mac (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (mac_valid[k]),
                .up_ready (mac_ready[k]),
                .up_item  (mac_item[k]),
                .dn_valid (mac_valid[k+1]),
                .dn_ready (mac_ready[k+1]),
                .dn_item  (mac_item[k+1])
            );
        end
    endgenerate

    kspa_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (mac_valid[kspa_pkg::N_MAC]),
        .up_ready    (mac_ready[kspa_pkg::N_MAC]),
        .up_item     (mac_item[kspa_pkg::N_MAC]),
        .dn_valid    (res.valid),
        .dn_ready    (res.ready),
        .value       (res.value),
        .range_error (res.range_error)
    );

    // out-of-range arguments always come out as zero
    a_rerr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.range_error |-> res.value == '0)
        else $error("range error word with nonzero value");

    // a free output side must open the whole ready chain back to the input
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        res.ready |-> arg.ready)
        else $error("input stalled while output side is ready");

    // a word accepted from the last scaling stage is seen at the output stage next
    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        mac_valid[kspa_pkg::N_MAC] && mac_ready[kspa_pkg::N_MAC] |=> res.valid)
        else $error("word lost entering the output stage");

endmodule
